// File: rtl/core/tiex_pkg.sv
package tiex_pkg;

  // datapath and instruction field geometry
  localparam int XLEN    = 32;
  localparam int REG_W   = 5;
  localparam int NREGS   = 32;
  localparam int OP_W    = 4;
  localparam int IMM_W   = 18;
  localparam int SHAMT_W = 13;
  localparam int JADDR_W = 28;

  localparam int OP_LSB = 28;
  localparam int RD_LSB = 23;
  localparam int RS_LSB = 18;
  localparam int RT_LSB = 13;

  // opcodes; codes 12..15 are unused
  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_MOVI = 4'd3,
    OP_JEQ  = 4'd4,
    OP_AND  = 4'd5,
    OP_XORI = 4'd6,
    OP_JMP  = 4'd7,
    OP_LSL  = 4'd8,
    OP_LSR  = 4'd9,
    OP_MOVR = 4'd10,
    OP_MOVM = 4'd11
  } op_t;

  // execute-stage control and status
  typedef struct packed {
    logic taken;
    logic reg_we;
    logic load;
    logic mem_we;
    logic mem_hit;
    logic fault;
    logic bad;
  } exe_ctl_t;

  // instruction field extraction
  function automatic op_t f_op(input logic [XLEN-1:0] ins);
    return op_t'(ins[OP_LSB +: OP_W]);
  endfunction

  function automatic logic [REG_W-1:0] f_rd(input logic [XLEN-1:0] ins);
    return ins[RD_LSB +: REG_W];
  endfunction

  function automatic logic [REG_W-1:0] f_rs(input logic [XLEN-1:0] ins);
    return ins[RS_LSB +: REG_W];
  endfunction

  function automatic logic [REG_W-1:0] f_rt(input logic [XLEN-1:0] ins);
    return ins[RT_LSB +: REG_W];
  endfunction

  // second register port reads rd for compare and store, rt otherwise
  function automatic logic [REG_W-1:0] f_rb(input logic [XLEN-1:0] ins);
    logic [REG_W-1:0] idx;
    idx = f_rt(ins);
    if (f_op(ins) == OP_JEQ || f_op(ins) == OP_MOVM) begin
      idx = f_rd(ins);
    end
    return idx;
  endfunction

endpackage

// File: rtl/core/tiex_ram.sv
module tiex_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/tiex_exec.sv
module tiex_exec import tiex_pkg::*; #(
  parameter int PROGRAM_WORDS = 1024,
  parameter int DATA_WORDS = 1024,
  localparam int PC_W = $clog2(PROGRAM_WORDS + 1),
  localparam int MIDX_W = $clog2(DATA_WORDS)
) (
  input  logic [XLEN-1:0]   instr,
  input  logic [PC_W-1:0]   pc,
  input  logic [XLEN-1:0]   opa,
  input  logic [XLEN-1:0]   opb,
  output exe_ctl_t          ctl,
  output logic [PC_W-1:0]   next_pc,
  output logic [XLEN-1:0]   result,
  output logic [MIDX_W-1:0] midx
);

  localparam logic [XLEN-1:0] PW_X = XLEN'(PROGRAM_WORDS);
  localparam logic [XLEN-1:0] DW_X = XLEN'(DATA_WORDS);
  localparam logic [PC_W:0]   PW_P = (PC_W + 1)'(PROGRAM_WORDS);

  op_t              op;
  logic [REG_W-1:0] rd;
  logic [XLEN-1:0]  imm;
  logic [SHAMT_W-1:0] shamt;
  logic             big_sh;
  logic [XLEN-1:0]  jaddr;
  logic [PC_W:0]    pc_inc;
  logic [PC_W-1:0]  seq_pc;
  logic [XLEN-1:0]  jeq_tgt;
  logic [XLEN-1:0]  ea;
  logic [XLEN-1:0]  off;
  logic             in_win;
  logic [XLEN-1:0]  prod;
  logic             has_res;

  // field decode
  assign op     = f_op(instr);
  assign rd     = f_rd(instr);
  assign imm    = XLEN'(instr[IMM_W-1:0]);
  assign shamt  = instr[SHAMT_W-1:0];
  assign big_sh = |shamt[SHAMT_W-1:5];
  assign jaddr  = XLEN'(instr[JADDR_W-1:0]);

  // sequential pc, saturating at the end of the program store
  assign pc_inc = {1'b0, pc} + (PC_W + 1)'(1);
  assign seq_pc = (pc_inc >= PW_P) ? PW_P[PC_W-1:0] : pc_inc[PC_W-1:0];

  // relative branch target
  assign jeq_tgt = XLEN'(pc) + XLEN'(1) + imm;

  // load/store window check
  assign ea     = opa + imm;
  assign off    = ea - PW_X;
  assign in_win = (ea >= PW_X) && (off < DW_X);
  assign midx   = off[MIDX_W-1:0];

  // low word of the product
  assign prod = opa * opb;

  // opcode dispatch
  always_comb begin
    ctl     = '0;
    has_res = 1'b0;
    result  = '0;
    next_pc = seq_pc;
    unique case (op)
      OP_ADD: begin
        result  = opa + opb;
        has_res = 1'b1;
      end
      OP_SUB: begin
        result  = opa - opb;
        has_res = 1'b1;
      end
      OP_MUL: begin
        result  = prod;
        has_res = 1'b1;
      end
      OP_MOVI: begin
        result  = imm;
        has_res = 1'b1;
      end
      OP_JEQ: begin
        if (opa == opb && jeq_tgt < PW_X) begin
          next_pc   = jeq_tgt[PC_W-1:0];
          ctl.taken = 1'b1;
        end
      end
      OP_AND: begin
        result  = opa & opb;
        has_res = 1'b1;
      end
      OP_XORI: begin
        result  = opa ^ imm;
        has_res = 1'b1;
      end
      OP_JMP: begin
        // target zero would need pc -1, so it is not taken
        if (jaddr != '0 && jaddr < PW_X) begin
          next_pc   = PC_W'(jaddr - XLEN'(1));
          ctl.taken = 1'b1;
        end
      end
      OP_LSL: begin
        result  = big_sh ? '0 : (opa << shamt[4:0]);
        has_res = 1'b1;
      end
      OP_LSR: begin
        result  = big_sh ? {XLEN{opa[XLEN-1]}} : XLEN'($signed(opa) >>> shamt[4:0]);
        has_res = 1'b1;
      end
      OP_MOVR: begin
        if (in_win) begin
          ctl.load    = 1'b1;
          ctl.mem_hit = 1'b1;
        end else begin
          ctl.fault = 1'b1;
        end
      end
      OP_MOVM: begin
        if (in_win) begin
          ctl.mem_we  = 1'b1;
          ctl.mem_hit = 1'b1;
        end else begin
          ctl.fault = 1'b1;
        end
      end
      default: begin
        ctl.bad = 1'b1;
      end
    endcase
    ctl.reg_we = has_res && (rd != '0);
  end

endmodule

// File: rtl/core/toy_isa_instruction_executor_unit.sv
// channel  dir  word                        fields (low bit up)
// in_      in   in_tdata[31:0]              instruction_word
// out_     out  out_tdata[OUT_W-1:0]        next_pc, branch_taken, reg_write, reg_index,
//                                           reg_value, mem_write, mem_index, mem_value,
//                                           addr_fault, bad_opcode, zero fill
//
// non-load instructions: one word per cycle while the output is free, register read
// at accept, execute and write back from the execute stage, operand forwarded from
// the last write back
// MOVR: the next word waits while it sits in execute; with a legal address its result
// word comes from the load stage after the data store read
// after reset the data store is cleared one word a cycle, in_tready stays low meanwhile
// a stalled output register holds the execute or load stage and then in_tready
module toy_isa_instruction_executor_unit import tiex_pkg::*; #(
  parameter int DATA_WORDS = 1024,
  parameter int PROGRAM_WORDS = 1024,
  localparam int PC_W = $clog2(PROGRAM_WORDS + 1),
  localparam int MIDX_W = $clog2(DATA_WORDS),
  localparam int OUT_BITS = PC_W + MIDX_W + 74,
  localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [31:0]      in_tdata,   // instruction_word
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // next_pc, branch_taken, reg_write, reg_index,
                                       // reg_value, mem_write, mem_index, mem_value,
                                       // addr_fault, bad_opcode
);

  typedef struct packed {
    logic              bad_opcode;
    logic              addr_fault;
    logic [XLEN-1:0]   mem_value;
    logic [MIDX_W-1:0] mem_index;
    logic              mem_write;
    logic [XLEN-1:0]   reg_value;
    logic [REG_W-1:0]  reg_index;
    logic              reg_write;
    logic              branch_taken;
    logic [PC_W-1:0]   next_pc;
  } res_t;

  logic accept;

  // clear pass
  logic              clr_busy_r, clr_busy_nxt;
  logic [MIDX_W-1:0] clr_idx_r, clr_idx_nxt;

  // execute stage
  logic             ex_vld_r, ex_vld_nxt;
  logic [XLEN-1:0]  ex_ins_r;
  logic [REG_W-1:0] ex_rb_r;
  logic             rfa_vld_r;
  logic             rfb_vld_r;
  logic [PC_W-1:0]  pc_r, pc_nxt;

  // load stage
  logic              ld_vld_r, ld_vld_nxt;
  logic              ld_we_r;
  logic [REG_W-1:0]  ld_idx_r;
  logic [PC_W-1:0]   ld_pc_r;
  logic [MIDX_W-1:0] ld_midx_r;

  // last register write back
  logic             wb_we_r, wb_we_nxt;
  logic [REG_W-1:0] wb_idx_r;
  logic [XLEN-1:0]  wb_val_r;
  logic [NREGS-1:0] rf_vld_r, rf_vld_nxt;

  // output register
  logic out_vld_r, out_vld_nxt;
  res_t out_data_r;

  logic [REG_W-1:0] rfa_raddr, rfb_raddr;
  logic [XLEN-1:0]  rfa_q, rfb_q;
  logic             rf_we;
  logic [REG_W-1:0] rf_widx;
  logic [XLEN-1:0]  rf_wdata;

  logic              dm_we;
  logic [MIDX_W-1:0] dm_waddr;
  logic [XLEN-1:0]   dm_wdata;
  logic              dm_re;
  logic [XLEN-1:0]   dm_q;

  logic [REG_W-1:0]  ex_rs, ex_rd;
  logic              ex_movr;
  logic [XLEN-1:0]   opa, opb;
  exe_ctl_t          ex_ctl;
  logic [PC_W-1:0]   ex_next_pc;
  logic [XLEN-1:0]   ex_result;
  logic [MIDX_W-1:0] ex_midx;
  logic              out_free, ex_go, ld_go;
  res_t              ex_res, ld_res;

  // handshake
  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_vld_r || out_tready;
  assign ex_go    = ex_vld_r && (ex_ctl.load || out_free);
  assign ld_go    = ld_vld_r && out_free;
  assign ex_movr  = (f_op(ex_ins_r) == OP_MOVR);
  assign in_tready = !clr_busy_r &&
                     (ex_vld_r ? (out_free && !ex_movr) : (!ld_vld_r || ld_go));

  // register file read addresses come straight from the accepted word
  assign rfa_raddr = f_rs(in_tdata);
  assign rfb_raddr = f_rb(in_tdata);

  // register write back, load stage and execute stage never both hold a word
  assign rf_we    = (ex_go && ex_ctl.reg_we) || (ld_go && ld_we_r);
  assign rf_widx  = ld_go ? ld_idx_r : ex_rd;
  assign rf_wdata = ld_go ? dm_q : ex_result;

  // two copies of the register file give two read ports
  tiex_ram #(.WIDTH(XLEN), .DEPTH(NREGS)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_widx),
    .wdata (rf_wdata),
    .re    (accept),
    .raddr (rfa_raddr),
    .rdata (rfa_q)
  );

  tiex_ram #(.WIDTH(XLEN), .DEPTH(NREGS)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_widx),
    .wdata (rf_wdata),
    .re    (accept),
    .raddr (rfb_raddr),
    .rdata (rfb_q)
  );

  // operand select: forward the last write back, unwritten registers read zero
  assign ex_rs = f_rs(ex_ins_r);
  assign ex_rd = f_rd(ex_ins_r);
  assign opa = (wb_we_r && wb_idx_r == ex_rs) ? wb_val_r : (rfa_vld_r ? rfa_q : '0);
  assign opb = (wb_we_r && wb_idx_r == ex_rb_r) ? wb_val_r : (rfb_vld_r ? rfb_q : '0);

  tiex_exec #(.PROGRAM_WORDS(PROGRAM_WORDS), .DATA_WORDS(DATA_WORDS)) u_exec (
    .instr   (ex_ins_r),
    .pc      (pc_r),
    .opa     (opa),
    .opb     (opb),
    .ctl     (ex_ctl),
    .next_pc (ex_next_pc),
    .result  (ex_result),
    .midx    (ex_midx)
  );

  // data store port: clear pass first, then stores and loads
  assign dm_we    = clr_busy_r || (ex_go && ex_ctl.mem_we);
  assign dm_waddr = clr_busy_r ? clr_idx_r : ex_midx;
  assign dm_wdata = clr_busy_r ? '0 : opb;
  assign dm_re    = ex_go && ex_ctl.load;

  tiex_ram #(.WIDTH(XLEN), .DEPTH(DATA_WORDS)) u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .re    (dm_re),
    .raddr (ex_midx),
    .rdata (dm_q)
  );

  // result word from the execute stage
  always_comb begin
    ex_res              = '0;
    ex_res.next_pc      = ex_next_pc;
    ex_res.branch_taken = ex_ctl.taken;
    ex_res.reg_write    = ex_ctl.reg_we;
    ex_res.reg_index    = ex_ctl.reg_we ? ex_rd : '0;
    ex_res.reg_value    = ex_ctl.reg_we ? ex_result : '0;
    ex_res.mem_write    = ex_ctl.mem_we;
    ex_res.mem_index    = ex_ctl.mem_hit ? ex_midx : '0;
    ex_res.mem_value    = ex_ctl.mem_we ? opb : '0;
    ex_res.addr_fault   = ex_ctl.fault;
    ex_res.bad_opcode   = ex_ctl.bad;
  end

  // result word from the load stage
  always_comb begin
    ld_res           = '0;
    ld_res.next_pc   = ld_pc_r;
    ld_res.reg_write = ld_we_r;
    ld_res.reg_index = ld_we_r ? ld_idx_r : '0;
    ld_res.reg_value = ld_we_r ? dm_q : '0;
    ld_res.mem_index = ld_midx_r;
  end

  // next state of control registers
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_idx_nxt  = clr_idx_r;
    if (clr_busy_r) begin
      if (clr_idx_r == MIDX_W'(DATA_WORDS - 1)) begin
        clr_busy_nxt = 1'b0;
      end else begin
        clr_idx_nxt = clr_idx_r + MIDX_W'(1);
      end
    end

    ex_vld_nxt = accept ? 1'b1 : (ex_go ? 1'b0 : ex_vld_r);
    ld_vld_nxt = (ex_go && ex_ctl.load) ? 1'b1 : (ld_go ? 1'b0 : ld_vld_r);
    pc_nxt     = ex_go ? ex_next_pc : pc_r;

    wb_we_nxt  = rf_we ? 1'b1 : wb_we_r;
    rf_vld_nxt = rf_vld_r;
    if (rf_we) begin
      rf_vld_nxt[rf_widx] = 1'b1;
    end

    if ((ex_go && !ex_ctl.load) || ld_go) begin
      out_vld_nxt = 1'b1;
    end else begin
      out_vld_nxt = out_vld_r && !out_tready;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
      ex_vld_r   <= 1'b0;
      ld_vld_r   <= 1'b0;
      pc_r       <= '0;
      wb_we_r    <= 1'b0;
      rf_vld_r   <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_idx_r  <= clr_idx_nxt;
      ex_vld_r   <= ex_vld_nxt;
      ld_vld_r   <= ld_vld_nxt;
      pc_r       <= pc_nxt;
      wb_we_r    <= wb_we_nxt;
      rf_vld_r   <= rf_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      ex_ins_r  <= in_tdata;
      ex_rb_r   <= rfb_raddr;
      rfa_vld_r <= rf_vld_r[rfa_raddr];
      rfb_vld_r <= rf_vld_r[rfb_raddr];
    end
    if (ex_go && ex_ctl.load) begin
      ld_we_r   <= (ex_rd != '0);
      ld_idx_r  <= ex_rd;
      ld_pc_r   <= ex_next_pc;
      ld_midx_r <= ex_midx;
    end
    if (rf_we) begin
      wb_idx_r <= rf_widx;
      wb_val_r <= rf_wdata;
    end
    if (ld_go) begin
      out_data_r <= ld_res;
    end else if (ex_go && !ex_ctl.load) begin
      out_data_r <= ex_res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_W'(out_data_r);

  // execute and load stages never hold a word at the same time
  a_stage_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ex_vld_r && ld_vld_r))
    else $error("execute and load stage both occupied");

  // nothing enters while the data store is being cleared
  a_clr_block: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !accept)
    else $error("word accepted during clear pass");

  // register zero is never written
  a_r0_const: assert property (@(posedge clk) disable iff (!rst_n)
    rf_we |-> (rf_widx != '0))
    else $error("write to register zero");

  // a load leaving execute sits alone in the load stage next cycle
  a_ld_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (ex_go && ex_ctl.load) |=> (ld_vld_r && !ex_vld_r))
    else $error("load stage handoff lost");

endmodule

// File: tb/tb_toy_isa_instruction_executor_unit.sv
`timescale 1ns / 1ps

module tb_toy_isa_instruction_executor_unit import tiex_pkg::*;;

  localparam int PROG_WORDS = 1024;
  localparam int DMEM_WORDS = 1024;
  localparam int OUT_W = 96;
  localparam int RES_BITS = 95;
  localparam logic [OP_W-1:0] OP_UNUSED = 4'd12;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_WORDS = 650;

  // result word, last field in the lowest bits
  typedef struct packed {
    logic        bad_opcode;
    logic        addr_fault;
    logic [31:0] mem_value;
    logic [9:0]  mem_index;
    logic        mem_write;
    logic [31:0] reg_value;
    logic [4:0]  reg_index;
    logic        reg_write;
    logic        branch_taken;
    logic [10:0] next_pc;
  } exec_result_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [31:0]      in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;

  // architectural state mirrored by the predictor
  logic [31:0] arch_pc;
  logic [31:0] arch_regs [NREGS];
  logic [31:0] arch_mem [DMEM_WORDS];

  exec_result_t pending_results[$];
  int           mismatch_count = 0;
  int           results_seen = 0;
  bit           gaps_on = 1'b1;
  bit           rx_hold_req = 1'b0;

  // directed stimulus table
  logic [31:0]  dir_word[$];
  bit           dir_typed[$];
  exec_result_t dir_exp[$];

  toy_isa_instruction_executor_unit #(
    .DATA_WORDS(DMEM_WORDS),
    .PROGRAM_WORDS(PROG_WORDS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // execute one instruction on the mirrored state
  function automatic exec_result_t execute_word(input logic [31:0] w);
    op_t          op;
    logic [4:0]   rd;
    logic [4:0]   rs;
    logic [4:0]   rt;
    logic [31:0]  imm;
    logic [31:0]  shamt;
    logic [31:0]  jaddr;
    logic [31:0]  a;
    logic [31:0]  b;
    logic [31:0]  val;
    logic [31:0]  ea;
    logic [31:0]  nxt;
    logic         has_val;
    exec_result_t r;
    op = op_t'(w[OP_LSB +: OP_W]);
    rd = w[RD_LSB +: REG_W];
    rs = w[RS_LSB +: REG_W];
    rt = w[RT_LSB +: REG_W];
    imm = 32'(w[IMM_W-1:0]);
    shamt = 32'(w[SHAMT_W-1:0]);
    jaddr = 32'(w[JADDR_W-1:0]);
    a = arch_regs[rs];
    b = arch_regs[rt];
    nxt = (arch_pc + 1 >= PROG_WORDS) ? PROG_WORDS : arch_pc + 1;
    r = '0;
    val = '0;
    has_val = 1'b0;
    case (op)
      OP_ADD: begin
        val = a + b;
        has_val = 1'b1;
      end
      OP_SUB: begin
        val = a - b;
        has_val = 1'b1;
      end
      OP_MUL: begin
        val = a * b;
        has_val = 1'b1;
      end
      OP_MOVI: begin
        val = imm;
        has_val = 1'b1;
      end
      OP_JEQ: begin
        if (a == arch_regs[rd] && arch_pc + 1 + imm < PROG_WORDS) begin
          nxt = arch_pc + 1 + imm;
          r.branch_taken = 1'b1;
        end
      end
      OP_AND: begin
        val = a & b;
        has_val = 1'b1;
      end
      OP_XORI: begin
        val = a ^ imm;
        has_val = 1'b1;
      end
      OP_JMP: begin
        if (jaddr >= 1 && jaddr < PROG_WORDS) begin
          nxt = jaddr - 1;
          r.branch_taken = 1'b1;
        end
      end
      OP_LSL: begin
        val = (shamt >= 32) ? '0 : a << shamt[4:0];
        has_val = 1'b1;
      end
      OP_LSR: begin
        val = (shamt >= 32) ? {32{a[31]}} : 32'($signed(a) >>> shamt[4:0]);
        has_val = 1'b1;
      end
      OP_MOVR, OP_MOVM: begin
        ea = a + imm;
        if (ea >= PROG_WORDS && ea - PROG_WORDS < DMEM_WORDS) begin
          r.mem_index = 10'(ea - PROG_WORDS);
          if (op == OP_MOVR) begin
            val = arch_mem[r.mem_index];
            has_val = 1'b1;
          end else begin
            r.mem_write = 1'b1;
            r.mem_value = arch_regs[rd];
            arch_mem[r.mem_index] = arch_regs[rd];
          end
        end else begin
          r.addr_fault = 1'b1;
        end
      end
      default: r.bad_opcode = 1'b1;
    endcase
    // r0 is never written
    if (has_val && rd != 0) begin
      arch_regs[rd] = val;
      r.reg_write = 1'b1;
      r.reg_index = rd;
      r.reg_value = val;
    end
    arch_pc = nxt;
    r.next_pc = 11'(nxt);
    return r;
  endfunction

  // instruction encoding
  function automatic logic [31:0] enc(input op_t op, input int rd, input int rs,
                                      input logic [17:0] imm);
    return {op, 5'(rd), 5'(rs), imm};
  endfunction

  function automatic logic [17:0] rt_imm(input int rt);
    return {5'(rt), 13'd0};
  endfunction

  function automatic logic [31:0] jmp_word(input int addr);
    return {OP_JMP, 28'(addr)};
  endfunction

  function automatic exec_result_t fixed(input int npc, input bit taken, input bit bad,
                                         input int ridx, input logic [31:0] rval);
    exec_result_t r;
    r = '0;
    r.next_pc = 11'(npc);
    r.branch_taken = taken;
    r.bad_opcode = bad;
    if (ridx != 0) begin
      r.reg_write = 1'b1;
      r.reg_index = 5'(ridx);
      r.reg_value = rval;
    end
    return r;
  endfunction

  task automatic add_row(input logic [31:0] w, input bit typed, input exec_result_t e);
    dir_word.push_back(w);
    dir_typed.push_back(typed);
    dir_exp.push_back(e);
  endtask

  // random instruction, mostly well formed, with load and store aimed at the data window
  function automatic logic [31:0] random_word();
    op_t         op;
    logic [4:0]  rd;
    logic [4:0]  rs;
    logic [17:0] imm;
    logic [31:0] target;
    logic [31:0] diff;
    int          sel;
    if ($urandom_range(0, 99) < 12) begin
      return $urandom();
    end
    op = op_t'($urandom_range(0, 11));
    rd = 5'($urandom());
    rs = 5'($urandom());
    imm = 18'($urandom());
    case (op)
      OP_LSL, OP_LSR: begin
        if ($urandom_range(0, 9) < 7) imm[SHAMT_W-1:0] = 13'($urandom_range(0, 40));
      end
      OP_JEQ: begin
        if ($urandom_range(0, 1) == 1) rs = rd;
        if ($urandom_range(0, 9) < 7) imm = 18'($urandom_range(0, 40));
      end
      OP_JMP: begin
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
          return jmp_word($urandom_range(0, 1100));
        end else if (sel < 8) begin
          return jmp_word($urandom_range(1000, 1030));
        end
        return jmp_word($urandom());
      end
      OP_MOVR, OP_MOVM: begin
        if ($urandom_range(0, 9) < 8) begin
          target = PROG_WORDS + (($urandom_range(0, 1) == 1) ? $urandom_range(0, 15) :
                                 $urandom_range(0, DMEM_WORDS - 1));
          diff = target - arch_regs[rs];
          if (diff < (1 << IMM_W)) begin
            imm = diff[17:0];
          end else begin
            rs = '0;
            imm = target[17:0];
          end
        end
      end
      default: ;
    endcase
    return {op, rd, rs, imm};
  endfunction

  // offer one word, predict it once taken
  task automatic send_word(input logic [31:0] w, input bit typed, input exec_result_t fixed_exp);
    exec_result_t p;
    @(negedge clk);
    while (gaps_on && $urandom_range(0, 99) < 18) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= w;
    do @(posedge clk); while (!in_tready);
    p = execute_word(w);
    pending_results.push_back(typed ? fixed_exp : p);
  endtask

  // result side ready, with random stalls and one long hold
  initial begin : result_ready
    int hold_left;
    hold_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        hold_left = HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(gaps_on && $urandom_range(0, 99) < 18);
      end
    end
  end

  // compare each result word with the oldest prediction
  always @(posedge clk) begin : result_check
    exec_result_t got;
    exec_result_t want;
    string        diffs;
    if (rst_n && out_tvalid && out_tready) begin
      got = exec_result_t'(out_tdata[RES_BITS-1:0]);
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("result word %0d arrived with nothing pending: %h", results_seen, got);
        end
      end else begin
        want = pending_results.pop_front();
        diffs = "";
        if (got.next_pc !== want.next_pc) diffs = {diffs, " next_pc"};
        if (got.branch_taken !== want.branch_taken) diffs = {diffs, " branch_taken"};
        if (got.reg_write !== want.reg_write) diffs = {diffs, " reg_write"};
        if (got.reg_index !== want.reg_index) diffs = {diffs, " reg_index"};
        if (got.reg_value !== want.reg_value) diffs = {diffs, " reg_value"};
        if (got.mem_write !== want.mem_write) diffs = {diffs, " mem_write"};
        if (got.mem_index !== want.mem_index) diffs = {diffs, " mem_index"};
        if (got.mem_value !== want.mem_value) diffs = {diffs, " mem_value"};
        if (got.addr_fault !== want.addr_fault) diffs = {diffs, " addr_fault"};
        if (got.bad_opcode !== want.bad_opcode) diffs = {diffs, " bad_opcode"};
        if (diffs != "") begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result word %0d differs in%s: expected %h, got %h",
                     results_seen, diffs, want, got);
          end
        end
      end
    end
  end

  // run limit
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    int i;
    int n;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    arch_pc = '0;
    for (i = 0; i < NREGS; i++) arch_regs[i] = '0;
    for (i = 0; i < DMEM_WORDS; i++) arch_mem[i] = '0;

    // write to r0, an unused opcode, widest immediate
    add_row(enc(OP_MOVI, 0, 0, '1), 1, fixed(1, 0, 0, 0, 0));
    add_row(32'hFFFF_FFFF, 1, fixed(2, 0, 1, 0, 0));
    add_row(enc(OP_MOVI, 1, 0, '1), 1, fixed(3, 0, 0, 1, 32'h0003_FFFF));
    // arithmetic and shifts, including shifts past the word width
    add_row(enc(OP_SUB, 2, 0, rt_imm(1)), 0, '0);
    add_row(enc(OP_LSL, 3, 2, 18'd14), 0, '0);
    add_row(enc(OP_XORI, 4, 2, 18'h2AAAA), 0, '0);
    add_row(enc(OP_LSR, 5, 2, 18'h1FFF), 0, '0);
    add_row(enc(OP_LSR, 5, 1, 18'd0), 0, '0);
    add_row(enc(OP_LSL, 6, 1, 18'd32), 0, '0);
    add_row(enc(OP_MUL, 6, 2, rt_imm(2)), 0, '0);
    add_row(enc(OP_ADD, 7, 1, rt_imm(2)), 0, '0);
    add_row(enc(OP_AND, 8, 2, rt_imm(4)), 0, '0);
    // data window edges, load into r0, faulting addresses incl. wrapped negative
    add_row(enc(OP_MOVI, 9, 0, 18'd1024), 0, '0);
    add_row(enc(OP_MOVM, 2, 9, 18'd0), 0, '0);
    add_row(enc(OP_MOVM, 1, 9, 18'd1023), 0, '0);
    add_row(enc(OP_MOVR, 10, 9, 18'd1023), 0, '0);
    add_row(enc(OP_MOVR, 0, 9, 18'd0), 0, '0);
    add_row(enc(OP_MOVR, 11, 9, 18'd1024), 0, '0);
    add_row(enc(OP_MOVM, 1, 0, 18'd1023), 0, '0);
    add_row(enc(OP_MOVR, 12, 2, 18'd5), 0, '0);
    // compare branches: taken, unequal, target past program store
    add_row(enc(OP_JEQ, 0, 0, 18'd3), 0, '0);
    add_row(enc(OP_JEQ, 1, 2, 18'd1), 0, '0);
    add_row(enc(OP_JEQ, 0, 7, '1), 0, '0);
    // jumps: address zero, out of range, lowest and highest legal
    add_row(jmp_word(0), 0, '0);
    add_row(jmp_word(28'hFFF_FFFF), 0, '0);
    add_row(jmp_word(1), 1, fixed(0, 1, 0, 0, 0));
    add_row(jmp_word(PROG_WORDS - 1), 1, fixed(PROG_WORDS - 2, 1, 0, 0, 0));
    // run off the program store, then keep executing at the saturated pc
    add_row({OP_UNUSED, 28'd0}, 1, fixed(PROG_WORDS - 1, 0, 1, 0, 0));
    add_row(enc(OP_MOVI, 14, 0, 18'd5), 1, fixed(PROG_WORDS, 0, 0, 14, 32'd5));
    add_row(enc(OP_ADD, 13, 14, rt_imm(14)), 0, '0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (i = 0; i < dir_word.size(); i++) begin
      send_word(dir_word[i], dir_typed[i], dir_exp[i]);
    end

    for (n = 0; n < RANDOM_WORDS; n++) begin
      // long result stall while words keep coming
      if (n == 150) rx_hold_req = 1'b1;
      // drain completely before going on
      if (n == 320) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      gaps_on = !(n >= 420 && n < 540);
      send_word(random_word(), 0, '0);
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
